// ===== design/stpf_pkg.sv =====
// Shared types and codes for the tagged packet descriptor FIFO.
package stpf_pkg;

    localparam int ACTION_W   = 3;
    localparam int HANDLE_W   = 16;
    localparam int SIZE_W     = 24;
    localparam int DURATION_W = 32;
    localparam int SERIAL_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 9;
    localparam int BYTES_W    = 33;
    localparam int DUR_TOT_W  = 40;
    localparam int OVERHEAD_W = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_GET   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ABORT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Register index, taken from paddr[2]
    localparam logic REG_ENTRY_OVERHEAD = 1'b0;

    localparam logic [OVERHEAD_W-1:0] OVERHEAD_RESET = 8'd16;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic [SIZE_W-1:0]     size;
        logic [DURATION_W-1:0] duration;
        logic [SERIAL_W-1:0]   serial;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/stpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/serial_tagged_packet_fifo_top.sv =====
// Top level of the tagged packet descriptor FIFO with APB register port.
//
// Each accepted transaction carries one action (put, get, flush, abort, start)
// and yields exactly one result transaction with status, the dequeued entry on
// a successful get, and the counters after the action. Descriptors live in one
// RAM of QUEUE_DEPTH entries with registered read data. Put, flush, abort,
// start and any refused get load the result on acceptance; a successful get
// first reads the RAM. The result sits in an output register, so the next
// transaction is taken while a result waits, unless a get is reading or that
// register is still full and stalled. Descriptor storage needs no clearing
// after reset. The queue leaves reset aborted: issue start first.
module serial_tagged_packet_fifo_top #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stpf_pkg::PADDR_W-1:0]      paddr,
    input  logic [stpf_pkg::PDATA_W-1:0]      pwdata,
    output logic [stpf_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [stpf_pkg::ACTION_W-1:0]     action,
    input  logic [stpf_pkg::HANDLE_W-1:0]     pkt_handle,
    input  logic [stpf_pkg::SIZE_W-1:0]       pkt_size,
    input  logic [stpf_pkg::DURATION_W-1:0]   pkt_duration,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stpf_pkg::STATUS_W-1:0]     status,
    output logic [stpf_pkg::HANDLE_W-1:0]     out_handle,
    output logic [stpf_pkg::SIZE_W-1:0]       out_size,
    output logic [stpf_pkg::DURATION_W-1:0]   out_duration,
    output logic [stpf_pkg::SERIAL_W-1:0]     out_serial,
    output logic [stpf_pkg::COUNT_W-1:0]      queued_count,
    output logic [stpf_pkg::BYTES_W-1:0]      queued_bytes,
    output logic [stpf_pkg::DUR_TOT_W-1:0]    queued_duration,
    output logic [stpf_pkg::SERIAL_W-1:0]     current_serial,
    output logic                              is_aborted
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_GET  = 1'b1;

    // ---------------- registers ----------------
    logic                               state_reg, state_next;
    logic [PTR_W-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [stpf_pkg::BYTES_W-1:0]       bytes_reg, bytes_next;
    logic [stpf_pkg::DUR_TOT_W-1:0]     dur_reg, dur_next;
    logic [stpf_pkg::SERIAL_W-1:0]      serial_reg, serial_next;
    logic                               abort_reg, abort_next;
    logic [stpf_pkg::OVERHEAD_W-1:0]    overhead_reg;

    logic                               out_valid_reg, out_valid_next;
    logic [stpf_pkg::STATUS_W-1:0]      status_reg, status_next;
    stpf_pkg::entry_t                   out_entry_reg, out_entry_next;

    // ---------------- handshake ----------------
    logic in_accept;
    logic out_load;
    logic out_free;
    logic cfg_write;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;

    // ---------------- descriptor RAM ----------------
    logic             ram_we;
    logic             ram_re;
    stpf_pkg::entry_t ram_wdata;
    stpf_pkg::entry_t ram_rdata;

    stpf_ram #(
        .WIDTH (stpf_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign ram_wdata.handle   = pkt_handle;
    assign ram_wdata.size     = pkt_size;
    assign ram_wdata.duration = pkt_duration;
    assign ram_wdata.serial   = serial_reg;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic is_empty;
    logic is_full;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        dur_next       = dur_reg;
        serial_next    = serial_reg;
        abort_next     = abort_reg;
        status_next    = status_reg;
        out_entry_next = out_entry_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    out_load       = 1'b1;
                    status_next    = stpf_pkg::ST_OK;
                    out_entry_next = '0;
                    unique case (action)
                        stpf_pkg::ACT_PUT:
                        begin
                            if (abort_reg)
                            begin
                                status_next = stpf_pkg::ST_ABORTED;
                            end
                            else if (is_full)
                            begin
                                status_next = stpf_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                wr_ptr_next = next_ptr(wr_ptr_reg);
                                count_next  = count_reg + 1'b1;
                                bytes_next  = bytes_reg
                                            + stpf_pkg::BYTES_W'(pkt_size)
                                            + stpf_pkg::BYTES_W'(overhead_reg);
                                dur_next    = dur_reg + stpf_pkg::DUR_TOT_W'(pkt_duration);
                            end
                        end
                        stpf_pkg::ACT_GET:
                        begin
                            if (abort_reg)
                            begin
                                status_next = stpf_pkg::ST_ABORTED;
                            end
                            else if (is_empty)
                            begin
                                status_next = stpf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // hold the result until the entry comes back
                                out_load   = 1'b0;
                                ram_re     = 1'b1;
                                state_next = S_GET;
                            end
                        end
                        stpf_pkg::ACT_FLUSH:
                        begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            count_next  = '0;
                            bytes_next  = '0;
                            dur_next    = '0;
                            serial_next = serial_reg + 1'b1;
                        end
                        stpf_pkg::ACT_ABORT:
                        begin
                            abort_next = 1'b1;
                        end
                        stpf_pkg::ACT_START:
                        begin
                            abort_next  = 1'b0;
                            serial_next = serial_reg + 1'b1;
                        end
                        default:
                        begin
                            status_next = stpf_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                out_load       = 1'b1;
                status_next    = stpf_pkg::ST_OK;
                out_entry_next = ram_rdata;
                rd_ptr_next    = next_ptr(rd_ptr_reg);
                count_next     = count_reg - 1'b1;
                bytes_next     = bytes_reg
                               - stpf_pkg::BYTES_W'(ram_rdata.size)
                               - stpf_pkg::BYTES_W'(overhead_reg);
                dur_next       = dur_reg - stpf_pkg::DUR_TOT_W'(ram_rdata.duration);
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            dur_reg       <= '0;
            serial_reg    <= '0;
            abort_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            dur_reg       <= dur_next;
            serial_reg    <= serial_next;
            abort_reg     <= abort_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- result payload ----------------
    logic [stpf_pkg::COUNT_W-1:0]   count_out_reg;
    logic [stpf_pkg::BYTES_W-1:0]   bytes_out_reg;
    logic [stpf_pkg::DUR_TOT_W-1:0] dur_out_reg;
    logic [stpf_pkg::SERIAL_W-1:0]  serial_out_reg;
    logic                           abort_out_reg;
    logic [CNT_W+stpf_pkg::COUNT_W-1:0] count_ext;

    assign count_ext = {{stpf_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg     <= status_next;
            out_entry_reg  <= out_entry_next;
            count_out_reg  <= count_ext[stpf_pkg::COUNT_W-1:0];
            bytes_out_reg  <= bytes_next;
            dur_out_reg    <= dur_next;
            serial_out_reg <= serial_next;
            abort_out_reg  <= abort_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign out_handle      = out_entry_reg.handle;
    assign out_size        = out_entry_reg.size;
    assign out_duration    = out_entry_reg.duration;
    assign out_serial      = out_entry_reg.serial;
    assign queued_count    = count_out_reg;
    assign queued_bytes    = bytes_out_reg;
    assign queued_duration = dur_out_reg;
    assign current_serial  = serial_out_reg;
    assign is_aborted      = abort_out_reg;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overhead_reg <= stpf_pkg::OVERHEAD_RESET;
        end
        else if (cfg_write && (paddr[2] == stpf_pkg::REG_ENTRY_OVERHEAD))
        begin
            overhead_reg <= pwdata[stpf_pkg::OVERHEAD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == stpf_pkg::REG_ENTRY_OVERHEAD)
                  ? stpf_pkg::PDATA_W'(overhead_reg) : '0;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_get_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GET) |-> $past(in_accept && (action == stpf_pkg::ACT_GET)
                                       && !abort_reg && !is_empty))
        else $error("read state entered without a valid get");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten while stalled");

    a_aborted_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == stpf_pkg::ST_ABORTED)) |-> abort_out_reg)
        else $error("aborted status without abort in force");

    a_get_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GET) |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("get did not complete in one read cycle");

endmodule
